[src/key_press_event_tracker_core_defines.svh]
// Assertion helpers used by the tracker RTL (kpet_track).
`ifndef KEY_PRESS_EVENT_TRACKER_CORE_DEFINES_SVH
`define KEY_PRESS_EVENT_TRACKER_CORE_DEFINES_SVH

// Sample on the rising clock edge and ignore cycles in reset.
`define KPET_CLK_RST @(posedge clk_i) disable iff (!rst_ni)

// Labeled concurrent assertion with an error message.
`define KPET_ASSERT(lbl, prop, msg) \
  lbl: assert property (`KPET_CLK_RST (prop)) else $error(msg);

`endif

[src/kpet_pkg.sv]
package kpet_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned WIN_W     = 8;
  localparam int unsigned CLICK_W   = 8;
  localparam int unsigned FLAG_W    = 4;

  localparam logic [CLICK_W-1:0] CLICK_MAX = '1;

  // Register reset values
  localparam logic [CNT_W-1:0] DOWN_TH_RST   = 10'd5;
  localparam logic [CNT_W-1:0] LONG_TH_RST   = 10'd50;
  localparam logic [CNT_W-1:0] CLAMP_RST     = 10'd10;
  localparam logic [CNT_W-1:0] REL_LIMIT_RST = 10'd200;
  localparam logic [CNT_W-1:0] CAP_RST       = 10'd1000;
  localparam logic [WIN_W-1:0] WINDOW_RST    = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IDLE      = 3'd0,
    CFG_DOWN_TH   = 3'd1,
    CFG_LONG_TH   = 3'd2,
    CFG_CLAMP     = 3'd3,
    CFG_REL_LIMIT = 3'd4,
    CFG_CAP       = 3'd5,
    CFG_WINDOW    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0] down_th;
    logic [CNT_W-1:0] long_th;
    logic [CNT_W-1:0] clamp;
    logic [CNT_W-1:0] rel_limit;
    logic [CNT_W-1:0] cap;
    logic [WIN_W-1:0] window;
  } kpet_cfg_t;

  typedef struct packed {
    logic long_ev;
    logic up;
    logic down;
    logic pressed;
  } kpet_flags_t;

endpackage

[src/key_press_event_tracker_core.sv]
// Channel  | Direction | Contents (low bit first)
// s_axis   | in        | key_value, key_data, clear_flags
// m_axis   | out       | pressed, down_event, up_event, long_event,
//          |           | reported_value, reported_data, click_count
// cfg      | in        | write enable, register index, write data
//
// One item per cycle while m_axis accepts results; a taken item is held in the
// input register, then the tracker state, which doubles as result register.
// The tracker state update is the single stage of logic per item.
// rst_ni clears all tracker state and loads register defaults.
// A stalled m_axis holds the result and the input register; s_axis_tready
// drops only when both are full.
module key_press_event_tracker_core #(
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // key_value, key_data, clear_flags, zero fill
  input  logic [((KEY_BITS+DATA_BITS+1+7)/8)*8-1:0]  s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // pressed, down_event, up_event, long_event, reported_value,
  // reported_data, click_count, zero fill
  output logic [((KEY_BITS+DATA_BITS+12+7)/8)*8-1:0] m_axis_tdata,
  input  logic                                   cfg_we_i,
  input  logic [kpet_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [((KEY_BITS > 10) ? KEY_BITS : 10)-1:0] cfg_data_i
);

  localparam int unsigned CFG_W  = (KEY_BITS > 10) ? KEY_BITS : 10;
  localparam int unsigned VAL_LO = kpet_pkg::FLAG_W;
  localparam int unsigned DAT_LO = VAL_LO + KEY_BITS;
  localparam int unsigned CNT_LO = DAT_LO + DATA_BITS;

  logic                    in_valid_q;
  logic [KEY_BITS-1:0]     in_key_q;
  logic [DATA_BITS-1:0]    in_dat_q;
  logic                    in_clr_q;
  logic                    out_valid_q;
  logic                    out_free;
  logic                    step;
  logic                    in_fire;

  logic [KEY_BITS-1:0]          idle;
  kpet_pkg::kpet_cfg_t          cfg;
  kpet_pkg::kpet_flags_t        flags;
  logic [KEY_BITS-1:0]          rep_val;
  logic [DATA_BITS-1:0]         rep_dat;
  logic [kpet_pkg::CLICK_W-1:0] clicks;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_key_q <= s_axis_tdata[KEY_BITS-1:0];
      in_dat_q <= s_axis_tdata[KEY_BITS +: DATA_BITS];
      in_clr_q <= s_axis_tdata[KEY_BITS+DATA_BITS];
    end
  end

  kpet_cfg_regs #(
    .KEY_BITS (KEY_BITS),
    .CFG_W    (CFG_W)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .idle_o (idle),
    .cfg_o  (cfg)
  );

  kpet_track #(
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .key_i   (in_key_q),
    .data_i  (in_dat_q),
    .clr_i   (in_clr_q),
    .idle_i  (idle),
    .cfg_i   (cfg),
    .flags_o (flags),
    .value_o (rep_val),
    .data_o  (rep_dat),
    .count_o (clicks)
  );

  always_comb begin
    m_axis_tdata                               = '0;
    m_axis_tdata[0]                            = flags.pressed;
    m_axis_tdata[1]                            = flags.down;
    m_axis_tdata[2]                            = flags.up;
    m_axis_tdata[3]                            = flags.long_ev;
    m_axis_tdata[VAL_LO +: KEY_BITS]           = rep_val;
    m_axis_tdata[DAT_LO +: DATA_BITS]          = rep_dat;
    m_axis_tdata[CNT_LO +: kpet_pkg::CLICK_W]  = clicks;
  end

  assign m_axis_tvalid = out_valid_q;

endmodule

[src/kpet_cfg_regs.sv]
module kpet_cfg_regs #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned CFG_W    = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic [kpet_pkg::CFG_IDX_W-1:0]     idx_i,
  input  logic [CFG_W-1:0]                   data_i,
  output logic [KEY_BITS-1:0]                idle_o,
  output kpet_pkg::kpet_cfg_t                cfg_o
);

  logic [KEY_BITS-1:0] idle_q;
  kpet_pkg::kpet_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q          <= '0;
      cfg_q.down_th   <= kpet_pkg::DOWN_TH_RST;
      cfg_q.long_th   <= kpet_pkg::LONG_TH_RST;
      cfg_q.clamp     <= kpet_pkg::CLAMP_RST;
      cfg_q.rel_limit <= kpet_pkg::REL_LIMIT_RST;
      cfg_q.cap       <= kpet_pkg::CAP_RST;
      cfg_q.window    <= kpet_pkg::WINDOW_RST;
    end else if (we_i) begin
      unique case (kpet_pkg::cfg_idx_e'(idx_i))
        kpet_pkg::CFG_IDLE:      idle_q          <= data_i[KEY_BITS-1:0];
        kpet_pkg::CFG_DOWN_TH:   cfg_q.down_th   <= data_i[kpet_pkg::CNT_W-1:0];
        kpet_pkg::CFG_LONG_TH:   cfg_q.long_th   <= data_i[kpet_pkg::CNT_W-1:0];
        kpet_pkg::CFG_CLAMP:     cfg_q.clamp     <= data_i[kpet_pkg::CNT_W-1:0];
        kpet_pkg::CFG_REL_LIMIT: cfg_q.rel_limit <= data_i[kpet_pkg::CNT_W-1:0];
        kpet_pkg::CFG_CAP:       cfg_q.cap       <= data_i[kpet_pkg::CNT_W-1:0];
        kpet_pkg::CFG_WINDOW:    cfg_q.window    <= data_i[kpet_pkg::WIN_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  assign idle_o = idle_q;
  assign cfg_o  = cfg_q;

endmodule

[src/kpet_track.sv]
`include "key_press_event_tracker_core_defines.svh"

module kpet_track #(
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [KEY_BITS-1:0]              key_i,
  input  logic [DATA_BITS-1:0]             data_i,
  input  logic                             clr_i,
  input  logic [KEY_BITS-1:0]              idle_i,
  input  kpet_pkg::kpet_cfg_t              cfg_i,
  output kpet_pkg::kpet_flags_t            flags_o,
  output logic [KEY_BITS-1:0]              value_o,
  output logic [DATA_BITS-1:0]             data_o,
  output logic [kpet_pkg::CLICK_W-1:0]     count_o
);

  logic [KEY_BITS-1:0]           stable_q, stable_d;
  logic [KEY_BITS-1:0]           click_pat_q, click_pat_d;
  logic [kpet_pkg::CNT_W-1:0]    hold_q, hold_d;
  logic [kpet_pkg::CLICK_W-1:0]  cnt_q, cnt_d;
  logic [kpet_pkg::WIN_W-1:0]    timer_q, timer_d;
  logic [KEY_BITS-1:0]           val_q, val_d;
  logic [DATA_BITS-1:0]          dat_q, dat_d;
  kpet_pkg::kpet_flags_t         flags_q, flags_d;

  always_comb begin
    stable_d    = stable_q;
    click_pat_d = click_pat_q;
    hold_d      = hold_q;
    cnt_d       = cnt_q;
    timer_d     = timer_q;
    val_d       = val_q;
    dat_d       = dat_q;
    flags_d     = clr_i ? '0 : flags_q;

    if (key_i != idle_i) begin
      if (stable_q == key_i) begin
        // steady press: count hold ticks up to the cap
        flags_d.pressed = 1'b1;
        if (hold_q < cfg_i.cap) begin
          hold_d = hold_q + kpet_pkg::CNT_W'(1);
        end
        if (hold_d == cfg_i.down_th) begin
          flags_d.down = 1'b1;
        end
        if (hold_d == cfg_i.long_th) begin
          flags_d.long_ev = 1'b1;
        end
      end else begin
        // new pattern: extend or restart the click run
        if (click_pat_q == key_i) begin
          if (cnt_q < kpet_pkg::CLICK_MAX) begin
            cnt_d = cnt_q + kpet_pkg::CLICK_W'(1);
          end
        end else begin
          cnt_d   = kpet_pkg::CLICK_W'(1);
          timer_d = cfg_i.window;
        end
        stable_d    = key_i;
        val_d       = key_i;
        dat_d       = data_i;
        click_pat_d = key_i;
        if (hold_q > cfg_i.clamp) begin
          hold_d          = cfg_i.clamp;
          flags_d.long_ev = 1'b0;
        end
      end
    end else begin
      flags_d.pressed = 1'b0;
      if (stable_q != key_i) begin
        stable_d = key_i;
        if (hold_q > cfg_i.down_th && hold_q < cfg_i.rel_limit) begin
          flags_d.up = 1'b1;
        end
      end
      hold_d = '0;
    end

    // repeat window: close the run when the timer runs out
    if (timer_d != '0) begin
      timer_d = timer_d - kpet_pkg::WIN_W'(1);
      if (timer_d == '0) begin
        click_pat_d = idle_i;
      end
    end else begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q    <= '0;
      click_pat_q <= '0;
      hold_q      <= '0;
      cnt_q       <= '0;
      timer_q     <= '0;
      val_q       <= '0;
      dat_q       <= '0;
      flags_q     <= '0;
    end else if (step_i) begin
      stable_q    <= stable_d;
      click_pat_q <= click_pat_d;
      hold_q      <= hold_d;
      cnt_q       <= cnt_d;
      timer_q     <= timer_d;
      val_q       <= val_d;
      dat_q       <= dat_d;
      flags_q     <= flags_d;
    end
  end

  assign flags_o = flags_q;
  assign value_o = val_q;
  assign data_o  = dat_q;
  assign count_o = cnt_q;

  `KPET_ASSERT(a_idle_releases, step_i && key_i == idle_i |=> !flags_q.pressed && hold_q == '0, "idle key left press state")
  `KPET_ASSERT(a_new_latches, step_i && key_i != idle_i && key_i != stable_q |=> val_q == $past(key_i) && stable_q == $past(key_i), "new pattern not latched")
  `KPET_ASSERT(a_hold_state, !step_i |=> $stable(val_q) && $stable(cnt_q) && $stable(flags_q), "state moved without an item")

endmodule
